@@ hdl/fbpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int CMD_W       = 2;
  localparam int FIELD_ADDR_W = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 9;
  localparam int STRIDE_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 2'd2;

  localparam logic [FIELD_ADDR_W-1:0] BASE_ADDR_RST     = 32'd0;
  localparam logic [STRIDE_W-1:0]     BLOCK_BYTES_RST   = 16'd4;
  localparam logic [COUNT_W-1:0]      BLOCKS_IN_USE_RST = 9'd256;

  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] base_addr;
    logic [STRIDE_W-1:0]     block_bytes;
    logic [COUNT_W-1:0]      blocks_in_use;
  } cfg_t;

endpackage

@@ hdl/fbpa_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_req_if
// Command channel: cmd plus the address returned by a free.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
  logic                             valid;
  logic                             ready;
  logic [fbpa_pkg::CMD_W-1:0]        cmd;
  logic [fbpa_pkg::FIELD_ADDR_W-1:0] free_addr;

  modport source (output valid, output cmd, output free_addr, input ready);
  modport sink   (input valid, input cmd, input free_addr, output ready);
endinterface

@@ hdl/fbpa_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Result channel: allocated address, status and free block count.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [fbpa_pkg::FIELD_ADDR_W-1:0] addr;
  logic [fbpa_pkg::STATUS_W-1:0]     status;
  logic [fbpa_pkg::COUNT_W-1:0]      free_blocks;

  modport source (output valid, output addr, output status, output free_blocks,
                  input ready);
  modport sink   (input valid, input addr, input status, input free_blocks,
                  output ready);
endinterface

@@ hdl/fbpa_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fbpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fbpa_pkg::CFG_INDEX_W-1:0] index;
  logic [fbpa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/fbpa_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_cfg_regs
// Configuration registers: base address, block stride, pool size.
// ----------------------------------------------------------------------------
module fbpa_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  fbpa_cfg_if.sink           cfg,
  output fbpa_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_addr     <= fbpa_pkg::BASE_ADDR_RST;
      regs.block_bytes   <= fbpa_pkg::BLOCK_BYTES_RST;
      regs.blocks_in_use <= fbpa_pkg::BLOCKS_IN_USE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fbpa_pkg::REG_BASE_ADDR: begin
          regs.base_addr <= cfg.data;
        end
        fbpa_pkg::REG_BLOCK_BYTES: begin
          regs.block_bytes <= cfg.data[fbpa_pkg::STRIDE_W-1:0];
        end
        fbpa_pkg::REG_BLOCKS_IN_USE: begin
          regs.blocks_in_use <= cfg.data[fbpa_pkg::COUNT_W-1:0];
        end
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

endmodule

@@ hdl/fbpa_ring_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ring_mem
// Free address ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ring_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/fbpa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Command sequencer: ring pointers, free count, init walk, result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
  parameter int POOL_DEPTH = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fbpa_pkg::cfg_t                cfg_regs,
  fbpa_req_if.sink                      req,
  fbpa_rsp_if.source                    rsp,
  output logic                          mem_we,
  output logic [$clog2(POOL_DEPTH)-1:0] mem_waddr,
  output logic [ADDR_WIDTH-1:0]         mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(POOL_DEPTH)-1:0] mem_raddr,
  input  logic [ADDR_WIDTH-1:0]         mem_rdata
);

  localparam int PTR_W = $clog2(POOL_DEPTH);
  // compare width: holds the pool depth and the configured block count
  localparam int CW = (PTR_W + 1 > fbpa_pkg::COUNT_W) ? PTR_W + 1 : fbpa_pkg::COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_INIT = 2'd2;

  localparam logic [fbpa_pkg::FIELD_ADDR_W-1:0] NO_ADDR = '0;

  logic [1:0]                        state;
  logic [PTR_W-1:0]                  take_ptr;
  logic [PTR_W-1:0]                  put_ptr;
  logic [fbpa_pkg::COUNT_W-1:0]      free_total;
  logic [PTR_W-1:0]                  init_idx;
  logic [ADDR_WIDTH-1:0]             init_addr;
  logic                              out_valid;
  logic [fbpa_pkg::FIELD_ADDR_W-1:0] out_addr;
  logic [fbpa_pkg::STATUS_W-1:0]     out_status;
  logic [fbpa_pkg::COUNT_W-1:0]      out_blocks;

  logic [CW-1:0] ring_n;
  logic          accept;
  logic          has_free;
  logic          ring_full;
  logic          init_last;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CW-1:0]    n);
    logic [CW-1:0] q;
    q = CW'(p) + CW'(1);
    if (q >= n || q >= CW'(POOL_DEPTH)) begin
      step_ptr = '0;
    end else begin
      step_ptr = q[PTR_W-1:0];
    end
  endfunction

  assign ring_n = (CW'(cfg_regs.blocks_in_use) > CW'(POOL_DEPTH)) ?
                  CW'(POOL_DEPTH) : CW'(cfg_regs.blocks_in_use);

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign has_free  = (free_total != '0);
  assign ring_full = (CW'(free_total) >= ring_n);
  assign init_last = ((CW'(init_idx) + CW'(1)) >= ring_n);

  // Ring accesses never overlap: the alloc read completes before the next
  // command is taken, and the init walk runs with the command channel closed.
  assign mem_re    = accept && (req.cmd == fbpa_pkg::CMD_ALLOC) && has_free;
  assign mem_raddr = take_ptr;
  assign mem_we    = (state == S_INIT) ||
                     (accept && (req.cmd == fbpa_pkg::CMD_FREE) && !ring_full);
  assign mem_waddr = (state == S_INIT) ? init_idx : put_ptr;
  assign mem_wdata = (state == S_INIT) ? init_addr : ADDR_WIDTH'(req.free_addr);

  assign rsp.valid       = out_valid;
  assign rsp.addr        = out_addr;
  assign rsp.status      = out_status;
  assign rsp.free_blocks = out_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      take_ptr   <= '0;
      put_ptr    <= '0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.cmd)
              fbpa_pkg::CMD_ALLOC: begin
                if (has_free) begin
                  take_ptr   <= step_ptr(take_ptr, ring_n);
                  free_total <= free_total - 1'b1;
                  out_blocks <= free_total - 1'b1;
                  state      <= S_READ;
                end else begin
                  out_valid  <= 1'b1;
                  out_addr   <= NO_ADDR;
                  out_status <= fbpa_pkg::STATUS_EMPTY;
                  out_blocks <= free_total;
                end
              end
              fbpa_pkg::CMD_FREE: begin
                out_valid <= 1'b1;
                out_addr  <= NO_ADDR;
                if (ring_full) begin
                  out_status <= fbpa_pkg::STATUS_FULL;
                  out_blocks <= free_total;
                end else begin
                  put_ptr    <= step_ptr(put_ptr, ring_n);
                  free_total <= free_total + 1'b1;
                  out_status <= fbpa_pkg::STATUS_OK;
                  out_blocks <= free_total + 1'b1;
                end
              end
              fbpa_pkg::CMD_INIT: begin
                if (ring_n == '0) begin
                  // empty pool: nothing to write
                  take_ptr   <= '0;
                  put_ptr    <= '0;
                  free_total <= '0;
                  out_valid  <= 1'b1;
                  out_addr   <= NO_ADDR;
                  out_status <= fbpa_pkg::STATUS_OK;
                  out_blocks <= '0;
                end else begin
                  init_idx  <= '0;
                  init_addr <= ADDR_WIDTH'(cfg_regs.base_addr);
                  state     <= S_INIT;
                end
              end
              default: begin
                // no operation
                out_valid  <= 1'b1;
                out_addr   <= NO_ADDR;
                out_status <= fbpa_pkg::STATUS_OK;
                out_blocks <= free_total;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          out_addr   <= fbpa_pkg::FIELD_ADDR_W'(mem_rdata);
          out_status <= fbpa_pkg::STATUS_OK;
          state      <= S_IDLE;
        end
        S_INIT: begin
          // one block address per cycle, stride added as we go
          init_idx  <= init_idx + 1'b1;
          init_addr <= init_addr + ADDR_WIDTH'(cfg_regs.block_bytes);
          if (init_last) begin
            take_ptr   <= '0;
            put_ptr    <= '0;
            free_total <= fbpa_pkg::COUNT_W'(ring_n);
            out_valid  <= 1'b1;
            out_addr   <= NO_ADDR;
            out_status <= fbpa_pkg::STATUS_OK;
            out_blocks <= fbpa_pkg::COUNT_W'(ring_n);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator over a ring of free block addresses.
// ----------------------------------------------------------------------------
// Commands arrive on req, one result per command leaves on rsp. A free,
// a no-op, an alloc on an empty pool and a rejected free register their
// result straight from the command; a successful alloc first reads the
// ring memory through its registered read port. Init writes one block
// address per cycle into the ring, ring size addresses in all, where ring
// size is min(blocks_in_use, POOL_DEPTH). One command is in flight at a
// time; the next is taken at the earliest in the cycle the previous result
// transfers, so a stalled result holds off the command channel. The ring
// contents are undefined after reset and need no clearing pass: there are
// no free blocks until an init or a free. Configure only while idle.
module fixed_block_pool_allocator #(
  parameter int POOL_DEPTH = 256,
  parameter int ADDR_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  fbpa_req_if.sink    req,
  fbpa_rsp_if.source  rsp,
  fbpa_cfg_if.sink    cfg
);

  localparam int PTR_W = $clog2(POOL_DEPTH);

  fbpa_pkg::cfg_t         cfg_regs;
  logic                   mem_we;
  logic [PTR_W-1:0]       mem_waddr;
  logic [ADDR_WIDTH-1:0]  mem_wdata;
  logic                   mem_re;
  logic [PTR_W-1:0]       mem_raddr;
  logic [ADDR_WIDTH-1:0]  mem_rdata;

  fbpa_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  fbpa_ring_mem #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (ADDR_WIDTH)
  ) u_ring_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbpa_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // ring read and write never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_re && mem_we))
    else $error("ring read and write in the same cycle");

  // while an alloc read is in flight no new command is taken
  a_read_interlock: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> !req.ready)
    else $error("command taken during ring read");

  // only a successful alloc carries an address
  a_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != fbpa_pkg::STATUS_OK) |-> (rsp.addr == '0))
    else $error("nonzero address with error status");

  // an empty report means no free blocks
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == fbpa_pkg::STATUS_EMPTY) |-> (rsp.free_blocks == '0))
    else $error("empty status with free blocks left");
`endif

endmodule
